@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define C2SA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2sa same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define C2SA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2sa next-cycle check failed");

`endif

@@ design/c2sa_pkg.sv @@
// ----------------------------------------------------------------------------
// c2sa_pkg
// Types and constants shared by the cartesian to spherical angle pipeline.
// ----------------------------------------------------------------------------
package c2sa_pkg;

    // CORDIC datapath: operands normalized with the top bit at NORM_TOP
    localparam int CORDIC_BITS = 56;
    localparam int NORM_TOP    = 52;
    localparam int NORM_STAGES = 6;
    localparam int ANGLE_BITS  = 32;

    // Result field widths
    localparam int RADIUS_BITS  = 32;
    localparam int AZIMUTH_BITS = 24;
    localparam int POLAR_BITS   = 23;

    // 90 degrees in Q8.16
    localparam logic [POLAR_BITS-1:0] DEG90_Q16 = 23'd5898240;

    // Radians Q2.30 to degrees Q8.16: multiply, then shift right by DEG_SHIFT
    localparam int               RAD2DEG_BITS = 30;
    localparam logic [29:0]      RAD2DEG_Q38  = 30'd961263669;
    localparam int               DEG_SHIFT    = 38;

    // atan(2^-i) in Q2.30, truncated; entries 27 to 30 are rounded up
    localparam logic signed [31:0] ATAN_Q30 [32] = '{
        32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
        32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
        32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
        32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
        32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
        32'sd1023,      32'sd511,       32'sd255,       32'sd127,
        32'sd63,        32'sd31,        32'sd15,        32'sd8,
        32'sd4,         32'sd2,         32'sd1,         32'sd0
    };

    // Flags that steer the azimuth special cases
    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic y_neg;
    } theta_flags_t;

    // Flags of the point that travel with the radius path
    typedef struct packed {
        logic x_zero;
        logic z_zero;
    } point_flags_t;

endpackage

@@ design/c2sa_in_if.sv @@
// ----------------------------------------------------------------------------
// c2sa_in_if
// Valid/ready channel that carries one point item (x, y, z).
// ----------------------------------------------------------------------------
interface c2sa_in_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

@@ design/c2sa_out_if.sv @@
// ----------------------------------------------------------------------------
// c2sa_out_if
// Valid/ready channel that carries one result item (radius, two angles and a degenerate flag).
// ----------------------------------------------------------------------------
interface c2sa_out_if;
    logic                                      valid;
    logic                                      ready;
    logic        [c2sa_pkg::RADIUS_BITS-1:0]   planar_radius;
    logic signed [c2sa_pkg::AZIMUTH_BITS-1:0]  azimuth_deg;
    logic        [c2sa_pkg::POLAR_BITS-1:0]    polar_deg;
    logic                                      degenerate;

    modport source (output valid, output planar_radius, output azimuth_deg,
                    output polar_deg, output degenerate, input ready);
    modport sink   (input valid, input planar_radius, input azimuth_deg,
                    input polar_deg, input degenerate, output ready);
endinterface

@@ design/c2sa_isqrt.sv @@
// ----------------------------------------------------------------------------
// c2sa_isqrt
// Pipelined floor square root, one root bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module c2sa_isqrt #(
    parameter int RW  = 32,
    parameter int SBW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [2*RW-1:0] in_sq,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_vld,
    output logic [RW-1:0]   out_root,
    output logic [SBW-1:0]  out_sb
);
    localparam int REMW = RW + 4;

    logic [REMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] sq_reg   [RW];
    logic            vld_reg  [RW];
    logic [SBW-1:0]  sb_reg   [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_stage
            logic [REMW-1:0] rem_in;
            logic [RW-1:0]   root_in;
            logic [2*RW-1:0] sq_in;
            logic            vld_in;
            logic [SBW-1:0]  sb_in;
            logic [REMW-1:0] rem_sh;
            logic [REMW-1:0] trial;
            logic            take;
            logic [REMW-1:0] rem_next;
            logic [RW-1:0]   root_next;
            logic [2*RW-1:0] sq_next;

            // select stage input
            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign sq_in   = in_sq;
                assign vld_in  = in_vld;
                assign sb_in   = in_sb;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign sq_in   = sq_reg[k-1];
                assign vld_in  = vld_reg[k-1];
                assign sb_in   = sb_reg[k-1];
            end

            // bring down two bits, try (root << 2) | 1
            assign rem_sh    = {rem_in[REMW-3:0], sq_in[2*RW-1 -: 2]};
            assign trial     = {{(REMW-RW-2){1'b0}}, root_in, 2'b01};
            assign take      = rem_sh >= trial;
            assign rem_next  = take ? (rem_sh - trial) : rem_sh;
            assign root_next = {root_in[RW-2:0], take};
            assign sq_next   = {sq_in[2*RW-3:0], 2'b00};

            // advance valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            // advance payload
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    sq_reg[k]   <= sq_next;
                    sb_reg[k]   <= sb_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_sb   = sb_reg[RW-1];

endmodule

@@ design/c2sa_cordic.sv @@
// ----------------------------------------------------------------------------
// c2sa_cordic
// Pipelined vectoring CORDIC: pair normalize, fixed steps, radians to degrees.
// ----------------------------------------------------------------------------
module c2sa_cordic #(
    parameter int STEPS = 24,
    parameter int IW    = 32,
    parameter int SBW   = 1
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  logic                                     in_vld,
    input  logic        [IW-1:0]                     in_a,
    input  logic signed [IW:0]                       in_b,
    input  logic        [SBW-1:0]                    in_sb,
    output logic                                     out_vld,
    output logic signed [c2sa_pkg::AZIMUTH_BITS-1:0] out_deg,
    output logic        [SBW-1:0]                    out_sb
);
    localparam int CW  = c2sa_pkg::CORDIC_BITS;
    localparam int NT  = c2sa_pkg::NORM_TOP;
    localparam int NS  = c2sa_pkg::NORM_STAGES;
    localparam int AW  = c2sa_pkg::ANGLE_BITS;
    localparam int PW  = AW - 1 + c2sa_pkg::RAD2DEG_BITS;
    localparam int QW  = PW + 1 - c2sa_pkg::DEG_SHIFT;
    localparam int DW  = c2sa_pkg::AZIMUTH_BITS;
    localparam int PLW = c2sa_pkg::POLAR_BITS;

    // ------------------------------------------------------------------
    // Normalize the pair so the larger magnitude has its top bit at NT
    // ------------------------------------------------------------------
    logic signed [CW-1:0] n_a_reg   [NS];
    logic signed [CW-1:0] n_b_reg   [NS];
    logic        [NT:0]   n_m_reg   [NS];
    logic                 n_vld_reg [NS];
    logic        [SBW-1:0] n_sb_reg [NS];

    logic        [IW:0]   b_neg;
    logic        [IW:0]   b_mag;
    logic signed [CW-1:0] a_ext;
    logic signed [CW-1:0] b_ext;
    logic        [NT:0]   m_ext;

    assign b_neg = -in_b;
    assign b_mag = in_b[IW] ? b_neg : in_b;
    assign a_ext = {{(CW-IW){1'b0}}, in_a};
    assign b_ext = {{(CW-IW-1){in_b[IW]}}, in_b};
    assign m_ext = {{(NT-IW){1'b0}}, b_mag} | {{(NT+1-IW){1'b0}}, in_a};

    genvar j;
    generate
        for (j = 0; j < NS; j++)
        begin : g_norm
            localparam int SH = 32 >> j;
            logic signed [CW-1:0]  a_in;
            logic signed [CW-1:0]  b_in;
            logic        [NT:0]    m_in;
            logic                  vld_in;
            logic        [SBW-1:0] sb_in;
            logic                  do_shift;
            logic signed [CW-1:0]  a_next;
            logic signed [CW-1:0]  b_next;
            logic        [NT:0]    m_next;

            if (j == 0)
            begin : g_first
                assign a_in   = a_ext;
                assign b_in   = b_ext;
                assign m_in   = m_ext;
                assign vld_in = in_vld;
                assign sb_in  = in_sb;
            end
            else
            begin : g_rest
                assign a_in   = n_a_reg[j-1];
                assign b_in   = n_b_reg[j-1];
                assign m_in   = n_m_reg[j-1];
                assign vld_in = n_vld_reg[j-1];
                assign sb_in  = n_sb_reg[j-1];
            end

            // shift when the top SH bits are all clear
            assign do_shift = (m_in[NT -: SH] == '0);
            assign a_next   = do_shift ? (a_in <<< SH) : a_in;
            assign b_next   = do_shift ? (b_in <<< SH) : b_in;
            assign m_next   = do_shift ? (m_in << SH) : m_in;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    n_vld_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    n_vld_reg[j] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_a_reg[j]  <= a_next;
                    n_b_reg[j]  <= b_next;
                    n_m_reg[j]  <= m_next;
                    n_sb_reg[j] <= sb_in;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Rotation steps, one per stage, driving b toward zero
    // ------------------------------------------------------------------
    logic signed [CW-1:0]  c_a_reg   [STEPS];
    logic signed [CW-1:0]  c_b_reg   [STEPS];
    logic signed [AW-1:0]  c_ang_reg [STEPS];
    logic                  c_vld_reg [STEPS];
    logic        [SBW-1:0] c_sb_reg  [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            localparam int S = i % 32;
            logic signed [CW-1:0]  a_in;
            logic signed [CW-1:0]  b_in;
            logic signed [AW-1:0]  ang_in;
            logic                  vld_in;
            logic        [SBW-1:0] sb_in;
            logic signed [CW-1:0]  a_next;
            logic signed [CW-1:0]  b_next;
            logic signed [AW-1:0]  ang_next;

            if (i == 0)
            begin : g_first
                assign a_in   = n_a_reg[NS-1];
                assign b_in   = n_b_reg[NS-1];
                assign ang_in = '0;
                assign vld_in = n_vld_reg[NS-1];
                assign sb_in  = n_sb_reg[NS-1];
            end
            else
            begin : g_rest
                assign a_in   = c_a_reg[i-1];
                assign b_in   = c_b_reg[i-1];
                assign ang_in = c_ang_reg[i-1];
                assign vld_in = c_vld_reg[i-1];
                assign sb_in  = c_sb_reg[i-1];
            end

            // rotate by the sign of b
            assign a_next   = b_in[CW-1] ? (a_in - (b_in >>> S)) : (a_in + (b_in >>> S));
            assign b_next   = b_in[CW-1] ? (b_in + (a_in >>> S)) : (b_in - (a_in >>> S));
            assign ang_next = b_in[CW-1] ? (ang_in - c2sa_pkg::ATAN_Q30[S])
                                         : (ang_in + c2sa_pkg::ATAN_Q30[S]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    c_vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    c_vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_a_reg[i]   <= a_next;
                    c_b_reg[i]   <= b_next;
                    c_ang_reg[i] <= ang_next;
                    c_sb_reg[i]  <= sb_in;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Radians to degrees: magnitude, multiply, round and clamp
    // ------------------------------------------------------------------
    logic        [AW-2:0]  d1_mag_reg,  d1_mag_next;
    logic                  d1_neg_reg,  d1_neg_next;
    logic                  d1_vld_reg;
    logic        [SBW-1:0] d1_sb_reg;
    logic        [PW-1:0]  d2_prod_reg, d2_prod_next;
    logic                  d2_neg_reg;
    logic                  d2_vld_reg;
    logic        [SBW-1:0] d2_sb_reg;
    logic signed [DW-1:0]  d3_deg_reg,  d3_deg_next;
    logic                  d3_vld_reg;
    logic        [SBW-1:0] d3_sb_reg;

    logic signed [AW-1:0]  ang_last;
    logic        [AW-1:0]  ang_neg;
    logic        [PW:0]    rnd;
    logic        [QW-1:0]  q;
    logic        [PLW-1:0] q_clamp;

    assign ang_last    = c_ang_reg[STEPS-1];
    assign ang_neg     = -ang_last;
    assign d1_neg_next = ang_last[AW-1];
    assign d1_mag_next = ang_last[AW-1] ? ang_neg[AW-2:0] : ang_last[AW-2:0];

    assign d2_prod_next = {{(PW-AW+1){1'b0}}, d1_mag_reg} *
                          {{(PW-c2sa_pkg::RAD2DEG_BITS){1'b0}}, c2sa_pkg::RAD2DEG_Q38};

    // round half up, clamp to 90 degrees, put the sign back
    assign rnd     = {1'b0, d2_prod_reg} + ((PW+1)'(1) << (c2sa_pkg::DEG_SHIFT - 1));
    assign q       = rnd[PW:c2sa_pkg::DEG_SHIFT];
    assign q_clamp = (q > QW'(c2sa_pkg::DEG90_Q16)) ? c2sa_pkg::DEG90_Q16 : q[PLW-1:0];
    assign d3_deg_next = d2_neg_reg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
            d3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d1_vld_reg <= c_vld_reg[STEPS-1];
            d2_vld_reg <= d1_vld_reg;
            d3_vld_reg <= d2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_mag_reg  <= d1_mag_next;
            d1_neg_reg  <= d1_neg_next;
            d1_sb_reg   <= c_sb_reg[STEPS-1];
            d2_prod_reg <= d2_prod_next;
            d2_neg_reg  <= d1_neg_reg;
            d2_sb_reg   <= d1_sb_reg;
            d3_deg_reg  <= d3_deg_next;
            d3_sb_reg   <= d2_sb_reg;
        end
    end

    assign out_vld = d3_vld_reg;
    assign out_deg = d3_deg_reg;
    assign out_sb  = d3_sb_reg;

endmodule

@@ design/cartesian_to_spherical_angles.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical_angles
// Point (x, y, z) to planar radius, azimuth and polar angle in degrees.
// ----------------------------------------------------------------------------
// The block takes one point item per cycle when the output side does not
// stall and returns one result item per point, in order. The depth comes
// from the square root, which resolves one radius bit per stage, and from
// the polar CORDIC behind it: six normalize stages, one stage per CORDIC
// step and three stages for the degree conversion. The azimuth CORDIC runs
// beside the radius path and its result waits in a delay line. A stall on
// the output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_angles #(
    parameter int CORDIC_STEPS = 24,
    parameter int COORD_BITS   = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    c2sa_in_if.sink       points,
    c2sa_out_if.source    results
);
    localparam int CB      = COORD_BITS;
    localparam int SQW     = 2 * CB;
    localparam int LOW     = (CB + 1) / 2;
    localparam int HIW     = CB - LOW;
    localparam int RPW     = (CB > 32) ? CB : 32;
    localparam int RB      = c2sa_pkg::RADIUS_BITS;
    localparam int DW      = c2sa_pkg::AZIMUTH_BITS;
    localparam int PLW     = c2sa_pkg::POLAR_BITS;
    localparam int PFW     = $bits(c2sa_pkg::point_flags_t);
    localparam int TFW     = $bits(c2sa_pkg::theta_flags_t);
    localparam int PHSBW   = 1 + PFW + RB;
    localparam int TDLY    = 3 + CB;

    localparam logic signed [DW-1:0] AZ_POS90 = {1'b0, c2sa_pkg::DEG90_Q16};
    localparam logic signed [DW-1:0] AZ_NEG90 = -AZ_POS90;

    logic en;

    // advance everything unless a result waits on a stalled output
    assign en           = !results.valid || results.ready;
    assign points.ready = en;

    // ------------------------------------------------------------------
    // Stage 0: take magnitudes and flags of the point
    // ------------------------------------------------------------------
    logic        [CB-1:0] mx_reg, mx_next;
    logic        [CB-1:0] my_reg, my_next;
    logic        [CB-1:0] mz_reg, mz_next;
    logic signed [CB:0]   tb_reg, tb_next;
    logic                 s0_vld_reg;
    c2sa_pkg::theta_flags_t s0_tf_reg, s0_tf_next;
    c2sa_pkg::point_flags_t s0_pf_reg, s0_pf_next;

    logic [CB:0] y_ext;

    assign mx_next = points.coord_x[CB-1] ? (~points.coord_x + 1'b1) : points.coord_x;
    assign my_next = points.coord_y[CB-1] ? (~points.coord_y + 1'b1) : points.coord_y;
    assign mz_next = points.coord_z[CB-1] ? (~points.coord_z + 1'b1) : points.coord_z;

    // fold the point into the right half plane for the azimuth
    assign y_ext   = {points.coord_y[CB-1], points.coord_y};
    assign tb_next = points.coord_x[CB-1] ? $signed(~y_ext + 1'b1) : $signed(y_ext);

    assign s0_tf_next.x_zero = (points.coord_x == '0);
    assign s0_tf_next.y_zero = (points.coord_y == '0);
    assign s0_tf_next.y_neg  = points.coord_y[CB-1];
    assign s0_pf_next.x_zero = (points.coord_x == '0);
    assign s0_pf_next.z_zero = (points.coord_z == '0);

    // ------------------------------------------------------------------
    // Stages 1 to 3: squares from half-width products, then their sum
    // ------------------------------------------------------------------
    logic [2*LOW-1:0]   x_ll_reg, x_ll_next, y_ll_reg, y_ll_next;
    logic [LOW+HIW-1:0] x_lh_reg, x_lh_next, y_lh_reg, y_lh_next;
    logic [2*HIW-1:0]   x_hh_reg, x_hh_next, y_hh_reg, y_hh_next;
    logic [SQW-1:0]     sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [SQW-1:0]     sum_reg, sum_next;
    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [PFW+CB-1:0]  s1_sb_reg, s2_sb_reg, s3_sb_reg;

    function automatic logic [SQW-1:0] sq_join(
        input logic [2*LOW-1:0]   ll,
        input logic [LOW+HIW-1:0] lh,
        input logic [2*HIW-1:0]   hh
    );
        logic [SQW-1:0] acc;
        acc = (SQW'(hh) << (2 * LOW)) + (SQW'(lh) << (LOW + 1)) + SQW'(ll);
        return acc;
    endfunction

    assign x_ll_next = mx_reg[LOW-1:0] * mx_reg[LOW-1:0];
    assign x_lh_next = mx_reg[LOW-1:0] * mx_reg[CB-1:LOW];
    assign x_hh_next = mx_reg[CB-1:LOW] * mx_reg[CB-1:LOW];
    assign y_ll_next = my_reg[LOW-1:0] * my_reg[LOW-1:0];
    assign y_lh_next = my_reg[LOW-1:0] * my_reg[CB-1:LOW];
    assign y_hh_next = my_reg[CB-1:LOW] * my_reg[CB-1:LOW];
    assign sqx_next  = sq_join(x_ll_reg, x_lh_reg, x_hh_reg);
    assign sqy_next  = sq_join(y_ll_reg, y_lh_reg, y_hh_reg);
    assign sum_next  = sqx_reg + sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= points.valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg    <= mx_next;
            my_reg    <= my_next;
            mz_reg    <= mz_next;
            tb_reg    <= tb_next;
            s0_tf_reg <= s0_tf_next;
            s0_pf_reg <= s0_pf_next;
            x_ll_reg  <= x_ll_next;
            x_lh_reg  <= x_lh_next;
            x_hh_reg  <= x_hh_next;
            y_ll_reg  <= y_ll_next;
            y_lh_reg  <= y_lh_next;
            y_hh_reg  <= y_hh_next;
            s1_sb_reg <= {s0_pf_reg, mz_reg};
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            s2_sb_reg <= s1_sb_reg;
            sum_reg   <= sum_next;
            s3_sb_reg <= s2_sb_reg;
        end
    end

    // ------------------------------------------------------------------
    // Planar radius
    // ------------------------------------------------------------------
    logic                    rt_vld;
    logic [CB-1:0]           rt_root;
    logic [PFW+CB-1:0]       rt_sb;
    c2sa_pkg::point_flags_t  rt_pf;
    logic [CB-1:0]           rt_mz;
    logic [RPW-1:0]          root_w;
    logic [RB-1:0]           radius;
    logic                    rho_zero;

    c2sa_isqrt #(
        .RW  (CB),
        .SBW (PFW + CB)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s3_vld_reg),
        .in_sq    (sum_reg),
        .in_sb    (s3_sb_reg),
        .out_vld  (rt_vld),
        .out_root (rt_root),
        .out_sb   (rt_sb)
    );

    assign rt_pf    = rt_sb[PFW+CB-1:CB];
    assign rt_mz    = rt_sb[CB-1:0];
    assign rho_zero = (rt_root == '0);

    // saturate the radius to the output field
    assign root_w = RPW'(rt_root);
    assign radius = (root_w > RPW'(32'hFFFF_FFFF)) ? {RB{1'b1}} : root_w[RB-1:0];

    // ------------------------------------------------------------------
    // Polar angle: atan(rho / |z|)
    // ------------------------------------------------------------------
    logic                   ph_vld;
    logic signed [DW-1:0]   ph_deg;
    logic [PHSBW-1:0]       ph_sb;
    logic                   ph_rho_zero;
    c2sa_pkg::point_flags_t ph_pf;
    logic [RB-1:0]          ph_radius;

    c2sa_cordic #(
        .STEPS (CORDIC_STEPS),
        .IW    (CB),
        .SBW   (PHSBW)
    ) u_polar (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (rt_vld),
        .in_a    (rt_mz),
        .in_b    ($signed({1'b0, rt_root})),
        .in_sb   ({rho_zero, rt_pf, radius}),
        .out_vld (ph_vld),
        .out_deg (ph_deg),
        .out_sb  (ph_sb)
    );

    assign ph_rho_zero = ph_sb[PHSBW-1];
    assign ph_pf       = ph_sb[PHSBW-2:RB];
    assign ph_radius   = ph_sb[RB-1:0];

    // ------------------------------------------------------------------
    // Azimuth: atan(y / x), then wait for the radius path
    // ------------------------------------------------------------------
    logic                   th_vld;
    logic signed [DW-1:0]   th_deg;
    logic [TFW-1:0]         th_sb;
    c2sa_pkg::theta_flags_t th_tf;
    logic signed [DW-1:0]   az_next;
    logic signed [DW-1:0]   tdly_az_reg  [TDLY];
    logic                   tdly_vld_reg [TDLY];

    c2sa_cordic #(
        .STEPS (CORDIC_STEPS),
        .IW    (CB),
        .SBW   (TFW)
    ) u_azimuth (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s0_vld_reg),
        .in_a    (mx_reg),
        .in_b    (tb_reg),
        .in_sb   (s0_tf_reg),
        .out_vld (th_vld),
        .out_deg (th_deg),
        .out_sb  (th_sb)
    );

    assign th_tf = th_sb;

    // apply the axis cases
    always_comb
    begin
        priority if (th_tf.x_zero)
        begin
            az_next = th_tf.y_zero ? '0 : (th_tf.y_neg ? AZ_NEG90 : AZ_POS90);
        end
        else if (th_tf.y_zero)
        begin
            az_next = '0;
        end
        else
        begin
            az_next = th_deg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < TDLY; n++)
            begin
                tdly_vld_reg[n] <= 1'b0;
            end
        end
        else if (en)
        begin
            tdly_vld_reg[0] <= th_vld;
            for (int n = 1; n < TDLY; n++)
            begin
                tdly_vld_reg[n] <= tdly_vld_reg[n-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdly_az_reg[0] <= az_next;
            for (int n = 1; n < TDLY; n++)
            begin
                tdly_az_reg[n] <= tdly_az_reg[n-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                 out_vld_reg, out_vld_next;
    logic [RB-1:0]        out_rad_reg;
    logic signed [DW-1:0] out_az_reg;
    logic [PLW-1:0]       out_pol_reg, out_pol_next;
    logic                 out_deg_reg;

    assign out_vld_next = ph_vld && tdly_vld_reg[TDLY-1];

    // polar cases: no radius, then z on the plane, then negative angle
    always_comb
    begin
        priority if (ph_rho_zero)
        begin
            out_pol_next = '0;
        end
        else if (ph_pf.z_zero)
        begin
            out_pol_next = c2sa_pkg::DEG90_Q16;
        end
        else if (ph_deg[DW-1])
        begin
            out_pol_next = '0;
        end
        else
        begin
            out_pol_next = ph_deg[PLW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rad_reg <= ph_radius;
            out_az_reg  <= tdly_az_reg[TDLY-1];
            out_pol_reg <= out_pol_next;
            out_deg_reg <= ph_pf.x_zero;
        end
    end

    assign results.valid         = out_vld_reg;
    assign results.planar_radius = out_rad_reg;
    assign results.azimuth_deg   = out_az_reg;
    assign results.polar_deg     = out_pol_reg;
    assign results.degenerate    = out_deg_reg;

endmodule

@@ design/c2sa_checker.sv @@
// ----------------------------------------------------------------------------
// c2sa_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c2sa_checker (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     in_ready,
    input logic                                     out_valid,
    input logic                                     out_ready,
    input logic        [c2sa_pkg::RADIUS_BITS-1:0]  planar_radius,
    input logic signed [c2sa_pkg::AZIMUTH_BITS-1:0] azimuth_deg,
    input logic        [c2sa_pkg::POLAR_BITS-1:0]   polar_deg,
    input logic                                     degenerate
);
    localparam int AZW = c2sa_pkg::AZIMUTH_BITS;
    localparam int RFW = c2sa_pkg::RADIUS_BITS + AZW + c2sa_pkg::POLAR_BITS + 1;
    localparam logic signed [AZW-1:0] AZ90 = {1'b0, c2sa_pkg::DEG90_Q16};

    logic [RFW-1:0] out_fields;
    logic           az_on_axis;

    // gather the result fields
    assign out_fields = {planar_radius, azimuth_deg, polar_deg, degenerate};
    assign az_on_axis = (azimuth_deg == '0) || (azimuth_deg == AZ90) ||
                        (azimuth_deg == -AZ90);

    // hold a stalled result item
    `C2SA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))

    // take a new item whenever no result waits
    `C2SA_ASSERT_SAME(a_in_ready, !out_valid, in_ready)

    // degenerate points sit on an axis
    `C2SA_ASSERT_SAME(a_degen_axis, out_valid && degenerate, az_on_axis)

    // polar angle stays within 90 degrees
    `C2SA_ASSERT_SAME(a_polar_range, out_valid, polar_deg <= c2sa_pkg::DEG90_Q16)

    // no planar radius gives no polar angle
    `C2SA_ASSERT_SAME(a_rho_zero, out_valid && planar_radius == 0, polar_deg == 0)

endmodule

bind cartesian_to_spherical_angles c2sa_checker u_c2sa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (points.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .planar_radius (results.planar_radius),
    .azimuth_deg   (results.azimuth_deg),
    .polar_deg     (results.polar_deg),
    .degenerate    (results.degenerate)
);
